/* hdl/lob_pkg.sv */
// Shared types and codes for the limit order book.
// Used by lob_cell, lob_side and limit_order_book.
package lob_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_FILL_BID = 2'd2;
  localparam logic [1:0] OP_FILL_ASK = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_NO_PRICE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_DUP = 3'd5;
  localparam logic [2:0] ST_CLAMP = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] order_id;
    logic        order_side;
    logic        has_price;
    logic [31:0] price_ticks;
    logic [31:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [63:0] bid_id;
    logic [31:0] bid_qty;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [63:0] ask_id;
    logic [31:0] ask_qty;
    logic        removed_side;
    logic [31:0] removed_price;
    logic [31:0] removed_qty;
  } out_item_t;

  // One resting order.
  typedef struct packed {
    logic [63:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } entry_t;

  // Command broadcast from the side controller to every cell.
  typedef struct packed {
    logic   ins;     // insert new entry
    logic   rem;     // remove matching entry, shift up
    logic   upd0;    // write qty of head
    entry_t ent;
    logic   is_ask;
  } cell_cmd_t;

endpackage

/* hdl/limit_order_book.sv */
// Limit order book top level: two sorted cell chains and result register.
// Depends on lob_pkg and lob_side.
//
// Use: one command item enters on in_valid/in_ready (in_item); one result
// item per command leaves on out_valid/out_ready (out_item).
// Each side is a chain of SIDE_DEPTH cells kept sorted best first, with
// arrival order among equal prices. Every cell compares its own order with
// the broadcast command at once, so an insert or removal shifts the whole
// chain together, every cell loading its new entry at once.
// Flow: the input handshake registers the item; while it is held, the
// chains' match and full flags are evaluated from it, and the commit
// applies the update and loads the result register. The result shows the
// top of book read combinationally from the cell heads after the update:
// out_valid rises when the commit is registered, and in_ready is low from
// the handshake until the commit, so no new item is taken until it commits.
// A new item is taken while an earlier result still waits in the output
// register, as long as that register is free by commit time; a stalled
// receiver holds the result and blocks the commit.
// Reset clears all cell valid bits and the handshake state; the books are
// empty at once, no clearing pass.
module limit_order_book #(
  parameter int SIDE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lob_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output lob_pkg::out_item_t out_item
);
  lob_pkg::in_item_t cur_r;
  logic              busy_r;
  logic              ov_r;
  logic [2:0]        st_r;
  logic              rs_r;
  logic [31:0]       rp_r, rq_r;

  lob_pkg::cell_cmd_t bcmd, acmd;
  logic            bhv, ahv, bfull, afull, bfound, afound;
  lob_pkg::entry_t bhe, ahe, bfe, afe;

  logic        commit;
  logic [2:0]  st_nxt;
  logic        rs_nxt;
  logic [31:0] rp_nxt, rq_nxt;

  // Commit can proceed when the result slot frees up this cycle.
  assign commit = busy_r & (~ov_r | out_ready);
  assign in_ready = ~busy_r;

  always_comb begin
    lob_pkg::entry_t ne;
    ne.id = cur_r.order_id;
    ne.price = cur_r.price_ticks;
    ne.qty = cur_r.quantity;
    bcmd = '0;
    acmd = '0;
    bcmd.ent = ne;
    acmd.ent = ne;
    acmd.is_ask = 1'b1;
    st_nxt = lob_pkg::ST_OK;
    rs_nxt = 1'b0;
    rp_nxt = '0;
    rq_nxt = '0;
    unique case (cur_r.operation)
      lob_pkg::OP_ADD: begin
        if (!cur_r.has_price) begin
          st_nxt = lob_pkg::ST_NO_PRICE;
        end else if (bfound || afound) begin
          st_nxt = lob_pkg::ST_DUP;
        end else if (cur_r.order_side) begin
          if (afull) st_nxt = lob_pkg::ST_FULL;
          else acmd.ins = commit;
        end else begin
          if (bfull) st_nxt = lob_pkg::ST_FULL;
          else bcmd.ins = commit;
        end
      end
      lob_pkg::OP_CANCEL: begin
        if (bfound) begin
          rp_nxt = bfe.price;
          rq_nxt = bfe.qty;
          bcmd.rem = commit;
        end else if (afound) begin
          rs_nxt = 1'b1;
          rp_nxt = afe.price;
          rq_nxt = afe.qty;
          acmd.rem = commit;
        end else begin
          st_nxt = lob_pkg::ST_NOT_FOUND;
        end
      end
      lob_pkg::OP_FILL_BID: begin
        bcmd.ent.id = bhe.id;
        if (!bhv) begin
          st_nxt = lob_pkg::ST_EMPTY;
        end else begin
          if (cur_r.quantity > bhe.qty) st_nxt = lob_pkg::ST_CLAMP;
          if (cur_r.quantity >= bhe.qty) bcmd.rem = commit;
          else bcmd.upd0 = commit;
          bcmd.ent.qty = bhe.qty - cur_r.quantity;
        end
      end
      default: begin
        acmd.ent.id = ahe.id;
        if (!ahv) begin
          st_nxt = lob_pkg::ST_EMPTY;
        end else begin
          if (cur_r.quantity > ahe.qty) st_nxt = lob_pkg::ST_CLAMP;
          if (cur_r.quantity >= ahe.qty) acmd.rem = commit;
          else acmd.upd0 = commit;
          acmd.ent.qty = ahe.qty - cur_r.quantity;
        end
      end
    endcase
  end

  lob_side #(.DEPTH(SIDE_DEPTH)) u_bid (
    .clk(clk), .rst_n(rst_n), .cmd(bcmd), .head_v(bhv), .head_e(bhe),
    .full(bfull), .found(bfound), .found_e(bfe)
  );
  lob_side #(.DEPTH(SIDE_DEPTH)) u_ask (
    .clk(clk), .rst_n(rst_n), .cmd(acmd), .head_v(ahv), .head_e(ahe),
    .full(afull), .found(afound), .found_e(afe)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) busy_r <= 1'b1;
      else if (commit) busy_r <= 1'b0;
      if (commit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (in_valid && in_ready) cur_r <= in_item;
    if (commit) begin
      st_r <= st_nxt;
      rs_r <= rs_nxt;
      rp_r <= rp_nxt;
      rq_r <= rq_nxt;
    end
  end

  // Top of book comes straight off the chain heads, which hold still
  // until the next commit, and that waits for this result to be taken.
  always_comb begin
    out_item = '0;
    out_item.status = st_r;
    out_item.bid_valid = bhv;
    out_item.ask_valid = ahv;
    if (bhv) begin
      out_item.bid_price = bhe.price;
      out_item.bid_id = bhe.id;
      out_item.bid_qty = bhe.qty;
    end
    if (ahv) begin
      out_item.ask_price = ahe.price;
      out_item.ask_id = ahe.id;
      out_item.ask_qty = ahe.qty;
    end
    out_item.removed_side = rs_r;
    out_item.removed_price = rp_r;
    out_item.removed_qty = rq_r;
  end
  assign out_valid = ov_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !((bcmd.ins || bcmd.rem || bcmd.upd0) && (acmd.ins || acmd.rem || acmd.upd0)))
    else $error("both sides updated by one item");
  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !busy_r && out_valid)
    else $error("commit did not produce result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(st_r))
    else $error("result lost under stall");
endmodule

/* hdl/lob_cell.sv */
// One slot of a sorted side: holds an order and shifts with neighbors.
// Depends on lob_pkg.
module lob_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lob_pkg::cell_cmd_t cmd,
  input  logic               prev_v,
  input  lob_pkg::entry_t    prev_e,
  input  logic               prev_ins_here, // an earlier cell takes the insert
  input  logic               next_v,
  input  lob_pkg::entry_t    next_e,
  input  logic               prev_hit,      // an earlier cell matched remove
  output logic               v,
  output lob_pkg::entry_t    e,
  output logic               ins_here,      // insert lands here or before
  output logic               hit,           // match here or before
  output logic               my_match
);
  logic            v_r, v_nxt;
  lob_pkg::entry_t e_r, e_nxt;
  logic            better;

  assign v = v_r;
  assign e = e_r;
  always_comb begin
    better = cmd.is_ask ? (e_r.price > cmd.ent.price) : (e_r.price < cmd.ent.price);
  end
  assign ins_here = prev_ins_here | ~v_r | better;
  assign my_match = v_r & (e_r.id == cmd.ent.id);
  assign hit = prev_hit | my_match;

  always_comb begin
    v_nxt = v_r;
    e_nxt = e_r;
    if (cmd.ins) begin
      if (prev_ins_here) begin
        v_nxt = prev_v;
        e_nxt = prev_e;
      end else if (ins_here) begin
        v_nxt = 1'b1;
        e_nxt = cmd.ent;
      end
    end else if (cmd.rem) begin
      if (hit) begin
        v_nxt = next_v;
        e_nxt = next_e;
      end
    end else if (cmd.upd0 && my_match) begin
      // the command carries the head id, so only the head takes the new qty
      e_nxt.qty = cmd.ent.qty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    e_r <= e_nxt;
  end
endmodule

/* hdl/lob_side.sv */
// One side of the book: a chain of lob_cell slots, head is best.
// Depends on lob_pkg and lob_cell.
module lob_side #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lob_pkg::cell_cmd_t cmd,
  output logic               head_v,
  output lob_pkg::entry_t    head_e,
  output logic               full,
  output logic               found,
  output lob_pkg::entry_t    found_e
);
  logic            v [DEPTH+1];
  lob_pkg::entry_t e [DEPTH+1];
  logic            insh [DEPTH+1];
  logic            hit [DEPTH+1];
  logic            mt [DEPTH];
  lob_pkg::entry_t sel [DEPTH+1];

  assign insh[0] = 1'b0;
  assign hit[0] = 1'b0;
  assign v[DEPTH] = 1'b0;
  assign e[DEPTH] = '0;
  assign sel[0] = '0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic            pv;
      lob_pkg::entry_t pe;
      if (g == 0) begin : g_h
        assign pv = 1'b0;
        assign pe = '0;
      end else begin : g_b
        assign pv = v[g-1];
        assign pe = e[g-1];
      end
      lob_cell u_cell (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .prev_v(pv), .prev_e(pe), .prev_ins_here(insh[g]),
        .next_v(v[g+1]), .next_e(e[g+1]), .prev_hit(hit[g]),
        .v(v[g]), .e(e[g]), .ins_here(insh[g+1]), .hit(hit[g+1]),
        .my_match(mt[g])
      );
      // ids are unique, so an OR of masked entries picks the match
      assign sel[g+1] = sel[g] | (mt[g] ? e[g] : '0);
    end
  endgenerate

  assign head_v = v[0];
  assign head_e = e[0];
  assign full = v[DEPTH-1];
  assign found = hit[DEPTH];
  assign found_e = sel[DEPTH];
endmodule
